// ----- design/fbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// fbrf_pkg - shared types and constants for the fill-byte run finder
// Record layout, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package fbrf_pkg;

  localparam int MAX_CAVES   = 32;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_W       = 32;
  localparam int IDX_W       = (MAX_CAVES > 1) ? $clog2(MAX_CAVES) : 1;
  localparam int CNT_W       = $clog2(MAX_CAVES + 1);
  localparam int CMP_W       = 8;

  localparam logic [7:0]       FILL_BYTE = 8'hCC;
  localparam logic [LEN_W-1:0] LEAST_RUN = LEN_W'(5);

  typedef enum logic [1:0] {
    REG_TEXT_BASE = 2'd0,
    REG_MIN_RUN   = 2'd1,
    REG_MAX_CAVES = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_SCAN,
    S_READ,
    S_CMP,
    S_EMIT,
    S_NONE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]       len;
    logic [OFFSET_BITS-1:0] off;
  } rec_t;

  // Record write and running count from the run tracker.
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    rec_t             rec;
    logic [CNT_W-1:0] total;
  } trk_evt_t;

endpackage

// ----- design/fbrf_run_track.sv -----
// ----------------------------------------------------------------------------
// fbrf_run_track - fill-byte run tracker
// Follows runs of the fill byte and flags each run that qualifies as a record.
// ----------------------------------------------------------------------------
module fbrf_run_track
  import fbrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  input  logic [31:0]      min_run,
  input  logic [5:0]       max_caves,
  output trk_evt_t         evt
);

  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic                   run_active_r, run_active_nxt;
  logic [OFFSET_BITS-1:0] run_start_r, run_start_nxt;
  logic [LEN_W-1:0]       run_length_r, run_length_nxt;
  logic [CNT_W-1:0]       record_count_r, record_count_nxt;

  logic                   is_fill;
  logic [LEN_W-1:0]       len_ext;
  logic [OFFSET_BITS-1:0] start_ext;
  logic                   cand_active;
  logic [LEN_W-1:0]       cand_len;
  logic [OFFSET_BITS-1:0] cand_start;
  logic                   room;
  logic                   wr;

  always_comb begin
    is_fill   = (data_byte == FILL_BYTE);
    start_ext = run_active_r ? run_start_r : byte_offset_r;
    if (!run_active_r) begin
      len_ext = LEN_W'(1);
    end else if (run_length_r != '1) begin
      len_ext = run_length_r + LEN_W'(1);
    end else begin
      len_ext = run_length_r;
    end

    // A fill byte on the last beat closes the extended run.
    cand_active = is_fill ? 1'b1 : run_active_r;
    cand_len    = is_fill ? len_ext : run_length_r;
    cand_start  = is_fill ? start_ext : run_start_r;

    room = (CMP_W'(record_count_r) < CMP_W'(max_caves)) &&
           (CMP_W'(record_count_r) < CMP_W'(MAX_CAVES));
    wr   = beat && (!is_fill || final_byte) && cand_active &&
           (min_run >= LEAST_RUN) && (cand_len >= min_run) && room;

    byte_offset_nxt  = byte_offset_r;
    run_active_nxt   = run_active_r;
    run_start_nxt    = run_start_r;
    run_length_nxt   = run_length_r;
    record_count_nxt = record_count_r;
    if (beat) begin
      if (final_byte) begin
        byte_offset_nxt  = '0;
        run_active_nxt   = 1'b0;
        run_start_nxt    = '0;
        run_length_nxt   = '0;
        record_count_nxt = '0;
      end else begin
        byte_offset_nxt = byte_offset_r + OFFSET_BITS'(1);
        if (is_fill) begin
          run_active_nxt = 1'b1;
          run_start_nxt  = start_ext;
          run_length_nxt = len_ext;
        end else begin
          run_active_nxt = 1'b0;
          run_length_nxt = '0;
        end
        if (wr) record_count_nxt = record_count_r + CNT_W'(1);
      end
    end

    evt.wr      = wr;
    evt.wr_idx  = record_count_r[IDX_W-1:0];
    evt.rec.len = cand_len;
    evt.rec.off = cand_start;
    evt.total   = record_count_r + CNT_W'(wr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r  <= '0;
      run_active_r   <= 1'b0;
      run_start_r    <= '0;
      run_length_r   <= '0;
      record_count_r <= '0;
    end else begin
      byte_offset_r  <= byte_offset_nxt;
      run_active_r   <= run_active_nxt;
      run_start_r    <= run_start_nxt;
      run_length_r   <= run_length_nxt;
      record_count_r <= record_count_nxt;
    end
  end

endmodule

// ----- design/fill_byte_run_finder_sorted_unit.sv -----
// ----------------------------------------------------------------------------
// fill_byte_run_finder_sorted_unit - fill-byte run finder, sorted output
// Records runs of 0xCC in a byte stream and emits them longest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one section byte per beat,
//   in_final_byte set on the last one. While scanning, a beat is taken
//   every cycle; a qualifying run is written to the record RAM when it ends.
//   After the final beat, in_stall stays high while the sorter runs: for each
//   pick, one compare unit walks all n stored records (one RAM read then one
//   compare per record) to pick the longest not yet sent, ties going to the
//   lower address. Each pick is sent as one beat on the output channel
//   (out_valid / out_stall), with last_result on the final beat. With no
//   records, one beat with cave_valid low and last_result high goes out
//   instead.
//   The output beat sits in a register; a stall there holds it and only
//   delays the next pick, and a new section may begin while it waits.
//   Reset (rst_n low, synchronous) restores text_base 0, min_run 5,
//   max_caves 32 and an empty scan. The record RAM is not cleared.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once.
// ----------------------------------------------------------------------------
module fill_byte_run_finder_sorted_unit
  import fbrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cave_address,
  output logic [31:0] out_cave_size,
  output logic        out_cave_valid,
  output logic        out_last_result
);

  // Configuration registers
  logic [63:0] text_base_r;
  logic [31:0] min_run_r;
  logic [5:0]  max_caves_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r <= '0;
      min_run_r   <= 32'd5;
      max_caves_r <= 6'd32;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEXT_BASE: text_base_r <= cfg_wdata;
        REG_MIN_RUN:   min_run_r   <= cfg_wdata[31:0];
        REG_MAX_CAVES: max_caves_r <= cfg_wdata[5:0];
        default:       ;
      endcase
    end
  end

  // Run tracking
  state_t   state_r, state_nxt;
  logic     in_beat;
  trk_evt_t evt;

  assign in_stall = (state_r != S_SCAN);
  assign in_beat  = in_valid && !in_stall;

  fbrf_run_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (in_beat),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .min_run    (min_run_r),
    .max_caves  (max_caves_r),
    .evt        (evt)
  );

  // Record RAM: one write port (scan), one registered read port (sorter)
  rec_t rec_mem [MAX_CAVES];
  rec_t rd_data_r;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;

  always_ff @(posedge clk) begin
    if (evt.wr) rec_mem[evt.wr_idx] <= evt.rec;
    rd_data_r <= rec_mem[scan_idx_r];
  end

  // Selection sequencer
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       emit_cnt_r, emit_cnt_nxt;
  logic [MAX_CAVES-1:0]   done_r, done_nxt;
  logic                   best_found_r, best_found_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  rec_t                   best_r, best_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_addr_r, out_addr_nxt;
  logic [31:0] out_size_r, out_size_nxt;
  logic        out_cv_r, out_cv_nxt;
  logic        out_last_r, out_last_nxt;
  logic        slot_free;
  logic        is_last;

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    emit_cnt_nxt   = emit_cnt_r;
    done_nxt       = done_r;
    scan_idx_nxt   = scan_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_addr_nxt   = out_addr_r;
    out_size_nxt   = out_size_r;
    out_cv_nxt     = out_cv_r;
    out_last_nxt   = out_last_r;
    slot_free      = !out_valid_r || !out_stall;
    is_last        = (emit_cnt_r + CNT_W'(1)) == n_r;

    case (state_r)
      S_SCAN: begin
        if (in_beat && in_final_byte) begin
          n_nxt          = evt.total;
          emit_cnt_nxt   = '0;
          done_nxt       = '0;
          scan_idx_nxt   = '0;
          best_found_nxt = 1'b0;
          state_nxt      = (evt.total == '0) ? S_NONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // strict compare keeps the lower index on equal lengths
        if (!done_r[scan_idx_r] &&
            (!best_found_r || (rd_data_r.len > best_r.len))) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = scan_idx_r;
          best_nxt       = rd_data_r;
        end
        if ((CNT_W'(scan_idx_r) + CNT_W'(1)) == n_r) begin
          state_nxt = S_EMIT;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          state_nxt    = S_READ;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_addr_nxt           = text_base_r + 64'(best_r.off);
          out_size_nxt           = best_r.len;
          out_cv_nxt             = 1'b1;
          out_last_nxt           = is_last;
          done_nxt[best_idx_r]   = 1'b1;
          emit_cnt_nxt           = emit_cnt_r + CNT_W'(1);
          scan_idx_nxt           = '0;
          best_found_nxt         = 1'b0;
          state_nxt              = is_last ? S_SCAN : S_READ;
        end
      end
      S_NONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_size_nxt  = '0;
          out_cv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      default: state_nxt = S_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SCAN;
      n_r          <= '0;
      emit_cnt_r   <= '0;
      done_r       <= '0;
      scan_idx_r   <= '0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      done_r       <= done_nxt;
      scan_idx_r   <= scan_idx_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    out_addr_r <= out_addr_nxt;
    out_size_r <= out_size_nxt;
    out_cv_r   <= out_cv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cave_address = out_addr_r;
  assign out_cave_size    = out_size_r;
  assign out_cave_valid   = out_cv_r;
  assign out_last_result  = out_last_r;

`ifndef SYNTHESIS
  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> (emit_cnt_r < n_r && best_found_r))
    else $error("emit with no pending record");

  a_final_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_final_byte) |=> (state_r == S_READ || state_r == S_NONE))
    else $error("final beat did not start the sorter");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cave_valid) |-> out_last_result)
    else $error("empty result not marked last");

  a_scan_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (CNT_W'(scan_idx_r) < n_r))
    else $error("sorter index past record count");
`endif

endmodule
